// ===== hdl/amrgb_pkg.sv =====
// Shared types, constants and the sine/cosine wheel tables for the colour wheel block.
package amrgb_pkg;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int MEAN_W   = 12;
    localparam int HUE_W    = 9;
    localparam int DUTY_W   = 14;
    localparam int ANG_W    = 7;
    localparam int CFG_IDX_W = 1;

    // Default parameter values
    localparam int DEF_SAMPLES_PER_MEAN = 10;
    localparam int DEF_ADC_BITS         = 12;

    // Colour wheel geometry
    localparam int SEG_LEN   = 90;
    localparam int HUE_SPAN  = 3 * SEG_LEN;
    localparam int DUTY_FULL = 10000;
    localparam int TABLE_W   = SEG_LEN * DUTY_W;

    // Threshold reset values
    localparam logic [DUTY_W-1:0] OFF_THR_RESET = 14'd10;
    localparam logic [DUTY_W-1:0] ON_THR_RESET  = 14'd9990;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_THR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_THR  = 1'b1;

    // LED drive modes
    typedef enum logic [1:0] {
        MODE_OFF = 2'd0,
        MODE_ON  = 2'd1,
        MODE_PWM = 2'd2
    } t_drive_mode;

    // Wheel segments: which pair of colours carries sine and cosine
    typedef enum logic [1:0] {
        SEG_RED_BLUE   = 2'd0,
        SEG_GREEN_RED  = 2'd1,
        SEG_BLUE_GREEN = 2'd2
    } t_segment;

    // Duties and modes for the three colours
    typedef struct packed {
        logic [DUTY_W-1:0] red_duty;
        logic [DUTY_W-1:0] green_duty;
        logic [DUTY_W-1:0] blue_duty;
        t_drive_mode       red_mode;
        t_drive_mode       green_mode;
        t_drive_mode       blue_mode;
    } t_wheel;

    // Divide by the denominator of series term n: (2n)(2n+1) for sine,
    // (2n-1)(2n) for cosine
    function automatic longint unsigned f_series_div(
        input longint unsigned x,
        input int              n,
        input logic            want_sin
    );
        longint unsigned q;
        case (n)
            1:       q = want_sin ? x / 64'd6   : x / 64'd2;
            2:       q = want_sin ? x / 64'd20  : x / 64'd12;
            3:       q = want_sin ? x / 64'd42  : x / 64'd30;
            4:       q = want_sin ? x / 64'd72  : x / 64'd56;
            5:       q = want_sin ? x / 64'd110 : x / 64'd90;
            6:       q = want_sin ? x / 64'd156 : x / 64'd132;
            7:       q = want_sin ? x / 64'd210 : x / 64'd182;
            8:       q = want_sin ? x / 64'd272 : x / 64'd240;
            9:       q = want_sin ? x / 64'd342 : x / 64'd306;
            10:      q = want_sin ? x / 64'd420 : x / 64'd380;
            11:      q = want_sin ? x / 64'd506 : x / 64'd462;
            12:      q = want_sin ? x / 64'd600 : x / 64'd552;
            13:      q = want_sin ? x / 64'd702 : x / 64'd650;
            14:      q = want_sin ? x / 64'd812 : x / 64'd756;
            default: q = x;
        endcase
        return q;
    endfunction

    // Build the sine or cosine table at elaboration: Q34 Taylor series at
    // x = a*157/9000 radians, floored to hundredths of a percent.
    function automatic logic [TABLE_W-1:0] f_wheel_table(input logic want_sin);
        logic [TABLE_W-1:0]  tbl;
        longint unsigned     a2k;
        longint unsigned     term;
        longint unsigned     v;
        longint              acc;
        tbl = '0;
        for (int a = 0; a < SEG_LEN; a++) begin
            a2k = longint'(a) * longint'(a) * 64'd24649;
            if (want_sin) begin
                term = ((longint'(a) * 64'd157) << 34) / 64'd9000;
            end else begin
                term = 64'd1 << 34;
            end
            acc = longint'(term);
            for (int n = 1; n <= 14; n++) begin
                term = f_series_div(term * a2k / 64'd81000000, n, want_sin);
                if ((n % 2) == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            v = (longint'(acc) * 64'd10000) >> 34;
            tbl[a*DUTY_W +: DUTY_W] = v[DUTY_W-1:0];
        end
        return tbl;
    endfunction

    localparam logic [TABLE_W-1:0] SIN_TABLE = f_wheel_table(1'b1);
    localparam logic [TABLE_W-1:0] COS_TABLE = f_wheel_table(1'b0);

endpackage

// ===== hdl/amrgb_wheel_map.sv =====
// Colour wheel lookup: segment and angle to three LED duties and drive modes.
module amrgb_wheel_map (
    input  amrgb_pkg::t_segment                  i_seg,
    input  logic [amrgb_pkg::ANG_W-1:0]          i_ang,
    input  logic [amrgb_pkg::DUTY_W-1:0]         i_off_thr,
    input  logic [amrgb_pkg::DUTY_W-1:0]         i_on_thr,
    output amrgb_pkg::t_wheel                    o_wheel
);

    logic [amrgb_pkg::DUTY_W-1:0] sin_val;
    logic [amrgb_pkg::DUTY_W-1:0] cos_val;
    logic [amrgb_pkg::DUTY_W-1:0] red_d;
    logic [amrgb_pkg::DUTY_W-1:0] green_d;
    logic [amrgb_pkg::DUTY_W-1:0] blue_d;

    // Off test wins over the on test
    function automatic amrgb_pkg::t_drive_mode f_mode(
        input logic [amrgb_pkg::DUTY_W-1:0] duty,
        input logic [amrgb_pkg::DUTY_W-1:0] off_thr,
        input logic [amrgb_pkg::DUTY_W-1:0] on_thr
    );
        amrgb_pkg::t_drive_mode m;
        if (duty < off_thr) begin
            m = amrgb_pkg::MODE_OFF;
        end else if (duty > on_thr) begin
            m = amrgb_pkg::MODE_ON;
        end else begin
            m = amrgb_pkg::MODE_PWM;
        end
        return m;
    endfunction

    // Read the sine and cosine tables
    always_comb begin
        sin_val = amrgb_pkg::SIN_TABLE[i_ang*amrgb_pkg::DUTY_W +: amrgb_pkg::DUTY_W];
        cos_val = amrgb_pkg::COS_TABLE[i_ang*amrgb_pkg::DUTY_W +: amrgb_pkg::DUTY_W];
    end

    // Route the pair to the colours of this segment
    always_comb begin
        case (i_seg)
            amrgb_pkg::SEG_RED_BLUE: begin
                red_d   = sin_val;
                green_d = '0;
                blue_d  = cos_val;
            end
            amrgb_pkg::SEG_GREEN_RED: begin
                red_d   = cos_val;
                green_d = sin_val;
                blue_d  = '0;
            end
            amrgb_pkg::SEG_BLUE_GREEN: begin
                red_d   = '0;
                green_d = cos_val;
                blue_d  = sin_val;
            end
            default: begin
                red_d   = '0;
                green_d = '0;
                blue_d  = '0;
            end
        endcase
    end

    // Pack duties and modes
    always_comb begin
        o_wheel.red_duty   = red_d;
        o_wheel.green_duty = green_d;
        o_wheel.blue_duty  = blue_d;
        o_wheel.red_mode   = f_mode(red_d, i_off_thr, i_on_thr);
        o_wheel.green_mode = f_mode(green_d, i_off_thr, i_on_thr);
        o_wheel.blue_mode  = f_mode(blue_d, i_off_thr, i_on_thr);
    end

endmodule

// ===== hdl/adc_mean_to_rgb_wheel_duty.sv =====
// Top level: sample averaging, hue mapping and RGB wheel duty pipeline.
//
// Usage: converter samples arrive on i_sample with i_valid; a sample is taken
// at a rising edge where i_valid is high and o_stall is low. Every
// SAMPLES_PER_MEAN samples close one group, which gives one result on o_valid
// (held until a rising edge with i_stall low): the floor mean, the hue step,
// three duties and three drive modes. Samples that do not close a group give
// no result.
// Throughput: one sample per cycle while o_stall is low. The result of a group
// passes to the output register after the edge that takes its last sample,
// through the stages in order: the accumulator, the reciprocal multiply for
// the mean, the hue multiply with segment split, and the table lookup with
// the threshold compares.
// Stall: while the receiver stalls, results back up through the stages;
// o_stall rises only on a group-closing sample that cannot enter a full
// pipeline, so other samples keep being taken.
// Reset (i_rst_n low, synchronous): the group sum and count clear, all stages
// empty, thresholds return to 10 and 9990. The user writes thresholds through
// i_cfg_we / i_cfg_idx / i_cfg_data only while the block is idle (unchecked).
module adc_mean_to_rgb_wheel_duty #(
    parameter int SAMPLES_PER_MEAN = amrgb_pkg::DEF_SAMPLES_PER_MEAN,
    parameter int ADC_BITS         = amrgb_pkg::DEF_ADC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [amrgb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [amrgb_pkg::DUTY_W-1:0]       i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [amrgb_pkg::SAMPLE_W-1:0]     i_sample,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [amrgb_pkg::MEAN_W-1:0]       o_mean_value,
    output logic [amrgb_pkg::HUE_W-1:0]        o_hue_step,
    output logic [amrgb_pkg::DUTY_W-1:0]       o_red_duty,
    output logic [amrgb_pkg::DUTY_W-1:0]       o_green_duty,
    output logic [amrgb_pkg::DUTY_W-1:0]       o_blue_duty,
    output logic [1:0]                         o_red_mode,
    output logic [1:0]                         o_green_mode,
    output logic [1:0]                         o_blue_mode
);

    localparam int CLOG_N  = $clog2(SAMPLES_PER_MEAN);
    localparam int COUNT_W = (CLOG_N > 0) ? CLOG_N : 1;
    localparam int SUM_W   = amrgb_pkg::SAMPLE_W + CLOG_N;
    // Reciprocal of the group size, exact floor for every sum below 2^SUM_W
    localparam int RECIP_K = SUM_W + CLOG_N;
    localparam int RECIP_W = RECIP_K + 1;
    localparam longint RECIP_M =
        ((64'd1 << RECIP_K) + SAMPLES_PER_MEAN - 1) / SAMPLES_PER_MEAN;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int HPROD_W = amrgb_pkg::MEAN_W + 9;
    localparam logic [amrgb_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
        amrgb_pkg::SAMPLE_W'((64'd1 << ADC_BITS) - 1);
    localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(SAMPLES_PER_MEAN - 1);
    localparam logic [amrgb_pkg::HUE_W-1:0] HUE_MAX =
        amrgb_pkg::HUE_W'(amrgb_pkg::HUE_SPAN - 1);

    // Threshold registers
    logic [amrgb_pkg::DUTY_W-1:0] r_off_thr;
    logic [amrgb_pkg::DUTY_W-1:0] r_on_thr;

    // Accumulator
    logic [SUM_W-1:0]   r_sum;
    logic [COUNT_W-1:0] r_count;
    logic [SUM_W-1:0]   n_sum;
    logic               last_sample;
    logic               in_fire;

    // Stage 1: closed group sum
    logic               r_s1_valid;
    logic [SUM_W-1:0]   r_s1_sum;
    // Stage 2: mean
    logic               r_s2_valid;
    logic [amrgb_pkg::MEAN_W-1:0] r_s2_mean;
    // Stage 3: mean, hue, segment and angle
    logic               r_s3_valid;
    logic [amrgb_pkg::MEAN_W-1:0] r_s3_mean;
    logic [amrgb_pkg::HUE_W-1:0]  r_s3_hue;
    amrgb_pkg::t_segment          r_s3_seg;
    logic [amrgb_pkg::ANG_W-1:0]  r_s3_ang;
    // Stage 4: output register
    logic               r_o_valid;
    logic [amrgb_pkg::MEAN_W-1:0] r_o_mean;
    logic [amrgb_pkg::HUE_W-1:0]  r_o_hue;
    amrgb_pkg::t_wheel            r_o_wheel;

    logic ready1;
    logic ready2;
    logic ready3;
    logic ready4;

    logic [PROD_W-1:0]            mean_prod;
    logic [amrgb_pkg::MEAN_W-1:0] n_mean;
    logic [HPROD_W-1:0]           hue_prod;
    logic [HPROD_W-1:0]           hue_full;
    logic [amrgb_pkg::HUE_W-1:0]  n_hue;
    amrgb_pkg::t_segment          n_seg;
    logic [amrgb_pkg::HUE_W-1:0]  seg_base;
    logic [amrgb_pkg::HUE_W-1:0]  ang_full;
    amrgb_pkg::t_wheel            n_wheel;

    // Handshake: a stage takes new data when empty or when it drains
    assign ready4      = !r_o_valid || !i_stall;
    assign ready3      = !r_s3_valid || ready4;
    assign ready2      = !r_s2_valid || ready3;
    assign ready1      = !r_s1_valid || ready2;
    assign last_sample = (r_count == LAST_COUNT);
    assign o_stall     = last_sample && !ready1;
    assign in_fire     = i_valid && !o_stall;
    assign n_sum       = r_sum + SUM_W'(i_sample & SAMPLE_MASK);

    // Write thresholds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_thr <= amrgb_pkg::OFF_THR_RESET;
            r_on_thr  <= amrgb_pkg::ON_THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                amrgb_pkg::CFG_OFF_THR: r_off_thr <= i_cfg_data;
                amrgb_pkg::CFG_ON_THR:  r_on_thr  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Accumulate samples; clear on the group's last sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (in_fire) begin
            if (last_sample) begin
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= n_sum;
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Stage 1: hold the closed group sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (ready1) begin
            r_s1_valid <= in_fire && last_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1 && in_fire && last_sample) begin
            r_s1_sum <= n_sum;
        end
    end

    // Stage 2: mean through the reciprocal multiply
    assign mean_prod = PROD_W'(r_s1_sum) * PROD_W'(RECIP_M);
    assign n_mean    = amrgb_pkg::MEAN_W'(mean_prod >> RECIP_K);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (ready2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready2 && r_s1_valid) begin
            r_s2_mean <= n_mean;
        end
    end

    // Stage 3: hue step, then split into segment and angle
    assign hue_prod = HPROD_W'(r_s2_mean) * HPROD_W'(amrgb_pkg::HUE_SPAN);
    assign hue_full = hue_prod >> ADC_BITS;
    assign n_hue    = (hue_full > HPROD_W'(HUE_MAX)) ? HUE_MAX :
                      hue_full[amrgb_pkg::HUE_W-1:0];

    always_comb begin
        if (n_hue >= amrgb_pkg::HUE_W'(2 * amrgb_pkg::SEG_LEN)) begin
            n_seg    = amrgb_pkg::SEG_BLUE_GREEN;
            seg_base = amrgb_pkg::HUE_W'(2 * amrgb_pkg::SEG_LEN);
        end else if (n_hue >= amrgb_pkg::HUE_W'(amrgb_pkg::SEG_LEN)) begin
            n_seg    = amrgb_pkg::SEG_GREEN_RED;
            seg_base = amrgb_pkg::HUE_W'(amrgb_pkg::SEG_LEN);
        end else begin
            n_seg    = amrgb_pkg::SEG_RED_BLUE;
            seg_base = '0;
        end
        ang_full = n_hue - seg_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (ready3) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready3 && r_s2_valid) begin
            r_s3_mean <= r_s2_mean;
            r_s3_hue  <= n_hue;
            r_s3_seg  <= n_seg;
            r_s3_ang  <= ang_full[amrgb_pkg::ANG_W-1:0];
        end
    end

    // Stage 4: table lookup and drive modes
    amrgb_wheel_map u_wheel_map (
        .i_seg     (r_s3_seg),
        .i_ang     (r_s3_ang),
        .i_off_thr (r_off_thr),
        .i_on_thr  (r_on_thr),
        .o_wheel   (n_wheel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (ready4) begin
            r_o_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready4 && r_s3_valid) begin
            r_o_mean  <= r_s3_mean;
            r_o_hue   <= r_s3_hue;
            r_o_wheel <= n_wheel;
        end
    end

    // Drive the result request
    assign o_valid      = r_o_valid;
    assign o_mean_value = r_o_mean;
    assign o_hue_step   = r_o_hue;
    assign o_red_duty   = r_o_wheel.red_duty;
    assign o_green_duty = r_o_wheel.green_duty;
    assign o_blue_duty  = r_o_wheel.blue_duty;
    assign o_red_mode   = 2'(r_o_wheel.red_mode);
    assign o_green_mode = 2'(r_o_wheel.green_mode);
    assign o_blue_mode  = 2'(r_o_wheel.blue_mode);

endmodule

// ===== bench/adc_mean_to_rgb_wheel_duty_tb.sv =====
// Self-checking testbench for the potentiometer mean to RGB colour wheel duty block.
module adc_mean_to_rgb_wheel_duty_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import amrgb_pkg::*;

    localparam int GROUP_LEN   = DEF_SAMPLES_PER_MEAN;
    localparam int IDLE_LIMIT  = 400;
    localparam int GROUPS_EACH = 19;
    localparam int MAX_WAIT    = 17;
    localparam int DRAIN_CYCLES = 8;

    // One colour wheel result as the block reports it
    typedef struct {
        logic [MEAN_W-1:0] mean_value;
        logic [HUE_W-1:0]  hue_step;
        logic [DUTY_W-1:0] red_duty;
        logic [DUTY_W-1:0] green_duty;
        logic [DUTY_W-1:0] blue_duty;
        t_drive_mode       red_mode;
        t_drive_mode       green_mode;
        t_drive_mode       blue_mode;
    } t_colour_result;

    // Q34 Taylor series of sin or cos at a*157/9000 rad, floored to hundredths of a percent
    function automatic int unsigned wheel_duty(int unsigned ang, bit is_sine);
        longint unsigned ang_sq;
        longint unsigned term;
        longint unsigned div;
        longint          sum;
        ang_sq = longint'(ang) * longint'(ang) * 64'd24649;
        if (is_sine) begin
            term = ((longint'(ang) * 64'd157) << 34) / 64'd9000;
        end else begin
            term = 64'd1 << 34;
        end
        sum = longint'(term);
        for (int n = 1; n <= 14; n++) begin
            if (is_sine) begin
                div = longint'(2 * n) * longint'(2 * n + 1);
            end else begin
                div = longint'(2 * n - 1) * longint'(2 * n);
            end
            term = term * ang_sq / 64'd81000000 / div;
            if (n % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        return int'((longint'(sum) * 64'd10000) >> 34);
    endfunction

    // Tracks the group sum and thresholds, and holds the results still owed by the block
    class wheel_scoreboard;
        logic [DUTY_W-1:0] off_thr;
        logic [DUTY_W-1:0] on_thr;
        logic [15:0]       group_sum;
        int unsigned       group_count;
        int unsigned       sine_lut[SEG_LEN];
        int unsigned       cosine_lut[SEG_LEN];
        t_colour_result    owed[$];
        int                errors;

        function new();
            for (int a = 0; a < SEG_LEN; a++) begin
                sine_lut[a]   = wheel_duty(a, 1'b1);
                cosine_lut[a] = wheel_duty(a, 1'b0);
            end
            off_thr     = OFF_THR_RESET;
            on_thr      = ON_THR_RESET;
            group_sum   = '0;
            group_count = 0;
            errors      = 0;
        endfunction

        function void set_threshold(logic [CFG_IDX_W-1:0] idx, logic [DUTY_W-1:0] val);
            if (idx == CFG_OFF_THR) begin
                off_thr = val;
            end else if (idx == CFG_ON_THR) begin
                on_thr = val;
            end
        endfunction

        // Off test first: a duty both below off and above on is held off
        function t_drive_mode drive_mode(int unsigned duty);
            if (duty < off_thr) begin
                return MODE_OFF;
            end
            if (duty > on_thr) begin
                return MODE_ON;
            end
            return MODE_PWM;
        endfunction

        // Accumulate one sample; a closing sample queues the wheel result
        function void note_sample(logic [SAMPLE_W-1:0] smp);
            t_colour_result r;
            int unsigned    mean;
            int unsigned    hue;
            int unsigned    ang;
            int unsigned    duty[3];
            t_segment       seg;
            group_sum   = group_sum + smp;
            group_count = group_count + 1;
            if (group_count < GROUP_LEN) begin
                return;
            end
            mean        = group_sum / GROUP_LEN;
            group_sum   = '0;
            group_count = 0;
            hue = (mean * HUE_SPAN) >> DEF_ADC_BITS;
            if (hue > HUE_SPAN - 1) begin
                hue = HUE_SPAN - 1;
            end
            seg = t_segment'(hue / SEG_LEN);
            ang = hue % SEG_LEN;
            case (seg)
                SEG_RED_BLUE: begin
                    duty = '{sine_lut[ang], 0, cosine_lut[ang]};
                end
                SEG_GREEN_RED: begin
                    duty = '{cosine_lut[ang], sine_lut[ang], 0};
                end
                default: begin
                    duty = '{0, cosine_lut[ang], sine_lut[ang]};
                end
            endcase
            r.mean_value = mean[MEAN_W-1:0];
            r.hue_step   = hue[HUE_W-1:0];
            r.red_duty   = duty[0][DUTY_W-1:0];
            r.green_duty = duty[1][DUTY_W-1:0];
            r.blue_duty  = duty[2][DUTY_W-1:0];
            r.red_mode   = drive_mode(duty[0]);
            r.green_mode = drive_mode(duty[1]);
            r.blue_mode  = drive_mode(duty[2]);
            owed.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Compare one delivered result with the oldest one owed
        function void check_result(t_colour_result got);
            t_colour_result want;
            if (owed.size() == 0) begin
                $error("result delivered with none owed (mean %0d)", got.mean_value);
                errors++;
                return;
            end
            want = owed.pop_front();
            compare_field("mean_value", want.mean_value, got.mean_value);
            compare_field("hue_step", want.hue_step, got.hue_step);
            compare_field("red_duty", want.red_duty, got.red_duty);
            compare_field("green_duty", want.green_duty, got.green_duty);
            compare_field("blue_duty", want.blue_duty, got.blue_duty);
            compare_field("red_mode", want.red_mode, got.red_mode);
            compare_field("green_mode", want.green_mode, got.green_mode);
            compare_field("blue_mode", want.blue_mode, got.blue_mode);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DUTY_W-1:0]    i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic [SAMPLE_W-1:0]  i_sample;
    logic                 o_valid;
    logic                 i_stall;
    logic [MEAN_W-1:0]    o_mean_value;
    logic [HUE_W-1:0]     o_hue_step;
    logic [DUTY_W-1:0]    o_red_duty;
    logic [DUTY_W-1:0]    o_green_duty;
    logic [DUTY_W-1:0]    o_blue_duty;
    logic [1:0]           o_red_mode;
    logic [1:0]           o_green_mode;
    logic [1:0]           o_blue_mode;

    wheel_scoreboard wheel_sb = new();
    int              idle_cycles = 0;
    int              sender_calm;
    int              receiver_calm;

    adc_mean_to_rgb_wheel_duty #(
        .SAMPLES_PER_MEAN(GROUP_LEN),
        .ADC_BITS(DEF_ADC_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_sample(i_sample),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_mean_value(o_mean_value),
        .o_hue_step(o_hue_step),
        .o_red_duty(o_red_duty),
        .o_green_duty(o_green_duty),
        .o_blue_duty(o_blue_duty),
        .o_red_mode(o_red_mode),
        .o_green_mode(o_green_mode),
        .o_blue_mode(o_blue_mode)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Draw a wait in cycles; now and then start a stretch with no waiting at all
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(15, 60);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // End the run when neither side moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one sample after a random gap and hold it until taken
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = draw_wait(sender_calm);
        for (int k = 0; k < gap; k++) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid  = 1'b1;
        i_sample = smp;
        do begin
            @(posedge i_clk);
        end while (!(i_valid && !o_stall));
        wheel_sb.note_sample(smp);
    endtask

    // One group: equal samples, uniform noise, or jitter round a centre
    task automatic send_group();
        int kind;
        int centre;
        int val;
        kind   = $urandom_range(0, 3);
        centre = $urandom_range(0, (1 << SAMPLE_W) - 1);
        for (int k = 0; k < GROUP_LEN; k++) begin
            if (kind <= 1) begin
                val = centre;
            end else if (kind == 2) begin
                val = $urandom_range(0, (1 << SAMPLE_W) - 1);
            end else begin
                val = centre + $urandom_range(0, 200) - 100;
                if (val < 0) val = 0;
                if (val > (1 << SAMPLE_W) - 1) val = (1 << SAMPLE_W) - 1;
            end
            send_sample(val[SAMPLE_W-1:0]);
        end
    endtask

    // Drop valid, wait for every owed result, then let the stages drain
    task automatic settle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (wheel_sb.owed.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUTY_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        wheel_sb.set_threshold(idx, val);
    endtask

    // Take each result after a random stall
    initial begin
        t_colour_result got;
        int             hold;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            hold = draw_wait(receiver_calm);
            for (int k = 0; k < hold; k++) begin
                @(negedge i_clk);
                i_stall = 1'b1;
            end
            @(negedge i_clk);
            i_stall = 1'b0;
            do begin
                @(posedge i_clk);
            end while (!(o_valid && !i_stall));
            got.mean_value = o_mean_value;
            got.hue_step   = o_hue_step;
            got.red_duty   = o_red_duty;
            got.green_duty = o_green_duty;
            got.blue_duty  = o_blue_duty;
            got.red_mode   = t_drive_mode'(o_red_mode);
            got.green_mode = t_drive_mode'(o_green_mode);
            got.blue_mode  = t_drive_mode'(o_blue_mode);
            wheel_sb.check_result(got);
        end
    end

    // Threshold settings per phase; the last two are drawn at random
    int unsigned off_setting[6] = '{0, 16383, 10000, 0, 0, 0};
    int unsigned on_setting[6]  = '{10000, 0, 0, 16383, 0, 0};

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_OFF_THR;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_sample      = '0;
        sender_calm   = 0;
        receiver_calm = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: bottom of the wheel, top of the wheel,
        // and the first step past the red/blue segment
        for (int k = 0; k < GROUP_LEN; k++) send_sample('0);
        for (int k = 0; k < GROUP_LEN; k++) send_sample('1);
        for (int k = 0; k < GROUP_LEN; k++) send_sample(SAMPLE_W'(1366));
        for (int k = 0; k < GROUPS_EACH; k++) send_group();
        settle();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph >= 4) begin
                off_setting[ph] = $urandom_range(0, 16383);
                on_setting[ph]  = $urandom_range(0, 16383);
            end
            write_reg(CFG_OFF_THR, off_setting[ph][DUTY_W-1:0]);
            write_reg(CFG_ON_THR, on_setting[ph][DUTY_W-1:0]);
            @(negedge i_clk);
            i_cfg_we = 1'b0;
            for (int k = 0; k < GROUPS_EACH; k++) send_group();
            settle();
        end

        if (wheel_sb.owed.size() != 0) begin
            $error("%0d results never delivered", wheel_sb.owed.size());
            wheel_sb.errors++;
        end
        if (wheel_sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
